/* rtl/cpu_load_alu_execute_unit_macros.svh */
`ifndef CPU_LOAD_ALU_EXECUTE_UNIT_MACROS_SVH
`define CPU_LOAD_ALU_EXECUTE_UNIT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define LAE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LAE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lae_pkg.sv */
package lae_pkg;

    localparam int AW = 16;

    typedef struct packed {
        logic [7:0]  operation;
        logic [15:0] immediate;
    } t_in;

    typedef struct packed {
        logic [7:0]  reg_a;
        logic [7:0]  reg_flags;
        logic [7:0]  reg_b;
        logic [7:0]  reg_c;
        logic [7:0]  reg_d;
        logic [7:0]  reg_e;
        logic [7:0]  reg_h;
        logic [7:0]  reg_l;
        logic [15:0] stack_pointer;
        logic [15:0] program_counter;
        logic [4:0]  cycle_count;
        logic        unsupported;
    } t_out;

    typedef struct packed {
        logic          we;
        logic          re;
        logic [AW-1:0] addr;
        logic [7:0]    wdata;
    } t_mem_req;

    localparam logic [7:0] OP_NOP      = 8'h00;
    localparam logic [7:0] OP_LD_BC_NN = 8'h01;
    localparam logic [7:0] OP_ST_BC_A  = 8'h02;
    localparam logic [7:0] OP_ST_NN_SP = 8'h08;
    localparam logic [7:0] OP_LD_A_BC  = 8'h0A;
    localparam logic [7:0] OP_LD_DE_NN = 8'h11;
    localparam logic [7:0] OP_ST_DE_A  = 8'h12;
    localparam logic [7:0] OP_LD_A_DE  = 8'h1A;
    localparam logic [7:0] OP_LD_HL_NN = 8'h21;
    localparam logic [7:0] OP_LDI_HL_A = 8'h22;
    localparam logic [7:0] OP_LDI_A_HL = 8'h2A;
    localparam logic [7:0] OP_LD_SP_NN = 8'h31;
    localparam logic [7:0] OP_LDD_HL_A = 8'h32;
    localparam logic [7:0] OP_LDD_A_HL = 8'h3A;
    localparam logic [7:0] OP_LD_HL_N  = 8'h36;
    localparam logic [7:0] OP_HALT     = 8'h76;
    localparam logic [7:0] OP_POP_BC   = 8'hC1;
    localparam logic [7:0] OP_PUSH_BC  = 8'hC5;
    localparam logic [7:0] OP_POP_DE   = 8'hD1;
    localparam logic [7:0] OP_PUSH_DE  = 8'hD5;
    localparam logic [7:0] OP_STH_N_A  = 8'hE0;
    localparam logic [7:0] OP_POP_HL   = 8'hE1;
    localparam logic [7:0] OP_STH_C_A  = 8'hE2;
    localparam logic [7:0] OP_PUSH_HL  = 8'hE5;
    localparam logic [7:0] OP_ST_NN_A  = 8'hEA;
    localparam logic [7:0] OP_LDH_A_N  = 8'hF0;
    localparam logic [7:0] OP_POP_AF   = 8'hF1;
    localparam logic [7:0] OP_LDH_A_C  = 8'hF2;
    localparam logic [7:0] OP_PUSH_AF  = 8'hF5;
    localparam logic [7:0] OP_LDHL_SPN = 8'hF8;
    localparam logic [7:0] OP_LD_SP_HL = 8'hF9;
    localparam logic [7:0] OP_LD_A_NN  = 8'hFA;

endpackage

/* rtl/lae_dmem.sv */
module lae_dmem (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lae_pkg::t_mem_req i_req,
    output logic [7:0]      o_rdata,
    output logic            o_busy
);
    import lae_pkg::*;

    logic [7:0]    r_mem [2**AW];
    logic [AW-1:0] r_clr_addr;
    logic          r_clr;
    logic [7:0]    r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == {AW{1'b1}}) begin
                r_clr <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            r_mem[r_clr_addr] <= 8'h00;
        end else if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr;

endmodule

/* rtl/lae_exec.sv */
module lae_exec (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  lae_pkg::t_in      i_in,
    output logic              o_stall,
    input  logic              i_go,
    output logic              o_fin,
    output lae_pkg::t_out     o_res,
    output lae_pkg::t_mem_req o_req,
    input  logic [7:0]        i_rdata,
    input  logic              i_mem_busy
);
    import lae_pkg::*;

    `include "cpu_load_alu_execute_unit_macros.svh"

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_B    = 2'd1;
    localparam logic [1:0] S_C    = 2'd2;

    logic [1:0]  r_state, n_state;
    logic [7:0]  r_op;
    logic [15:0] r_imm;
    logic [7:0]  r_lo;
    logic [7:0]  r_a, r_f, r_b, r_c, r_d, r_e, r_h, r_l;
    logic [7:0]  n_a, n_f, n_b, n_c, n_d, n_e, n_h, n_l;
    logic [15:0] r_sp, n_sp, r_pc, n_pc;

    logic        acc, two, is_pop, wr_b;
    logic [7:0]  cur_op, sv, wd_b, wd_c, phi, plo, n8, res8;
    logic [15:0] cur_imm, prim, sec, bc, de, hl, ext, hlsum;
    logic [2:0]  d, s;
    logic        cin, sub;
    logic [8:0]  add9, sub9, lsum;
    logic [4:0]  addh, subh, hsum;
    logic [1:0]  len;
    logic [4:0]  cyc;
    logic        bad;

    assign bc  = {r_b, r_c};
    assign de  = {r_d, r_e};
    assign hl  = {r_h, r_l};
    assign acc = (r_state == S_IDLE) && i_valid && !i_mem_busy;
    assign o_stall = (r_state != S_IDLE) || i_mem_busy;

    assign cur_op  = (r_state == S_IDLE) ? i_in.operation : r_op;
    assign cur_imm = (r_state == S_IDLE) ? i_in.immediate : r_imm;
    assign d  = r_op[5:3];
    assign s  = r_op[2:0];
    assign n8 = r_imm[7:0];

    assign is_pop = (r_op == OP_POP_BC) || (r_op == OP_POP_DE) || (r_op == OP_POP_HL) ||
                    (r_op == OP_POP_AF);
    assign two = is_pop || (r_op == OP_PUSH_BC) || (r_op == OP_PUSH_DE) ||
                 (r_op == OP_PUSH_HL) || (r_op == OP_PUSH_AF) || (r_op == OP_ST_NN_SP);

    always_comb begin
        case (cur_op)
            OP_LD_A_BC, OP_ST_BC_A: prim = bc;
            OP_LD_A_DE, OP_ST_DE_A: prim = de;
            OP_LD_A_NN, OP_ST_NN_A, OP_ST_NN_SP: prim = cur_imm;
            OP_LDH_A_C, OP_STH_C_A: prim = {8'hFF, r_c};
            OP_LDH_A_N, OP_STH_N_A: prim = {8'hFF, cur_imm[7:0]};
            OP_PUSH_BC, OP_PUSH_DE, OP_PUSH_HL, OP_PUSH_AF: prim = r_sp - 16'd1;
            OP_POP_BC, OP_POP_DE, OP_POP_HL, OP_POP_AF: prim = r_sp;
            default: prim = hl;
        endcase
        case (r_op)
            OP_PUSH_BC, OP_PUSH_DE, OP_PUSH_HL, OP_PUSH_AF: sec = r_sp - 16'd2;
            OP_POP_BC, OP_POP_DE, OP_POP_HL, OP_POP_AF: sec = r_sp + 16'd1;
            default: sec = r_imm + 16'd1;
        endcase
    end

    always_comb begin
        case (s)
            3'd0: sv = r_b;
            3'd1: sv = r_c;
            3'd2: sv = r_d;
            3'd3: sv = r_e;
            3'd4: sv = r_h;
            3'd5: sv = r_l;
            3'd6: sv = i_rdata;
            default: sv = r_a;
        endcase
        case (r_op[5:4])
            2'd0: begin phi = r_b; plo = r_c; end
            2'd1: begin phi = r_d; plo = r_e; end
            2'd2: begin phi = r_h; plo = r_l; end
            default: begin phi = r_a; plo = r_f; end
        endcase
    end

    // memory-side write decode
    always_comb begin
        wr_b = 1'b0;
        wd_b = r_a;
        wd_c = r_sp[15:8];
        if (r_op[7:6] == 2'b01 && r_op != OP_HALT && d == 3'd6) begin
            wr_b = 1'b1;
            wd_b = sv;
        end
        case (r_op)
            OP_LD_HL_N: begin wr_b = 1'b1; wd_b = n8; end
            OP_ST_BC_A, OP_ST_DE_A, OP_ST_NN_A, OP_STH_C_A, OP_LDD_HL_A,
            OP_LDI_HL_A, OP_STH_N_A: wr_b = 1'b1;
            OP_PUSH_BC, OP_PUSH_DE, OP_PUSH_HL, OP_PUSH_AF: begin
                wr_b = 1'b1;
                wd_b = phi;
                wd_c = plo;
            end
            OP_ST_NN_SP: begin wr_b = 1'b1; wd_b = r_sp[7:0]; end
            default: ;
        endcase
    end

    always_comb begin
        o_req = '0;
        o_req.addr = prim[AW-1:0];
        case (r_state)
            S_IDLE: o_req.re = acc;
            S_B: begin
                if (is_pop) begin
                    o_req.re   = 1'b1;
                    o_req.addr = sec[AW-1:0];
                end else begin
                    o_req.we    = wr_b && (two || i_go);
                    o_req.wdata = wd_b;
                end
            end
            S_C: begin
                o_req.we    = !is_pop && i_go;
                o_req.addr  = sec[AW-1:0];
                o_req.wdata = wd_c;
            end
            default: ;
        endcase
    end

    assign o_fin = ((r_state == S_B) && !two && i_go) || ((r_state == S_C) && i_go);

    // alu and sp+n arithmetic
    always_comb begin
        cin   = r_op[3] & r_f[4];
        sub   = r_op[4];
        add9  = {1'b0, r_a} + {1'b0, sv} + {8'd0, cin};
        addh  = {1'b0, r_a[3:0]} + {1'b0, sv[3:0]} + {4'd0, cin};
        sub9  = {1'b0, r_a} - {1'b0, sv} - {8'd0, cin};
        subh  = {1'b0, r_a[3:0]} - {1'b0, sv[3:0]} - {4'd0, cin};
        res8  = sub ? sub9[7:0] : add9[7:0];
        ext   = {{8{n8[7]}}, n8};
        hlsum = r_sp + ext;
        hsum  = {1'b0, r_sp[3:0]} + {1'b0, n8[3:0]};
        lsum  = {1'b0, r_sp[7:0]} + {1'b0, n8};
    end

    always_comb begin
        n_a = r_a; n_f = r_f; n_b = r_b; n_c = r_c;
        n_d = r_d; n_e = r_e; n_h = r_h; n_l = r_l;
        n_sp = r_sp;
        len = 2'd1;
        cyc = 5'd4;
        bad = 1'b0;
        if (r_op[7:6] == 2'b01 && r_op != OP_HALT) begin
            case (d)
                3'd0: n_b = sv;
                3'd1: n_c = sv;
                3'd2: n_d = sv;
                3'd3: n_e = sv;
                3'd4: n_h = sv;
                3'd5: n_l = sv;
                3'd7: n_a = sv;
                default: ;
            endcase
            cyc = (d == 3'd6 || s == 3'd6) ? 5'd8 : 5'd4;
        end else if (r_op[7:5] == 3'b100) begin
            n_a = res8;
            n_f = {res8 == 8'd0, sub, sub ? subh[4] : addh[4], sub ? sub9[8] : add9[8], 4'd0};
            cyc = (s == 3'd6) ? 5'd8 : 5'd4;
        end else if ((r_op & 8'hC7) == 8'h06) begin
            case (d)
                3'd0: n_b = n8;
                3'd1: n_c = n8;
                3'd2: n_d = n8;
                3'd3: n_e = n8;
                3'd4: n_h = n8;
                3'd5: n_l = n8;
                3'd7: n_a = n8;
                default: ;
            endcase
            len = 2'd2;
            cyc = (d == 3'd6) ? 5'd12 : 5'd8;
        end else begin
            case (r_op)
                OP_NOP: ;
                OP_LD_A_BC, OP_LD_A_DE, OP_LDH_A_C: begin n_a = i_rdata; cyc = 5'd8; end
                OP_LD_A_NN: begin n_a = i_rdata; len = 2'd3; cyc = 5'd16; end
                OP_ST_BC_A, OP_ST_DE_A, OP_STH_C_A: cyc = 5'd8;
                OP_ST_NN_A: begin len = 2'd3; cyc = 5'd16; end
                OP_LDD_A_HL: begin
                    n_a = i_rdata; {n_h, n_l} = hl - 16'd1; cyc = 5'd8;
                end
                OP_LDD_HL_A: begin {n_h, n_l} = hl - 16'd1; cyc = 5'd8; end
                OP_LDI_A_HL: begin
                    n_a = i_rdata; {n_h, n_l} = hl + 16'd1; cyc = 5'd8;
                end
                OP_LDI_HL_A: begin {n_h, n_l} = hl + 16'd1; cyc = 5'd8; end
                OP_STH_N_A: begin len = 2'd2; cyc = 5'd12; end
                OP_LDH_A_N: begin n_a = i_rdata; len = 2'd2; cyc = 5'd12; end
                OP_LD_BC_NN: begin {n_b, n_c} = r_imm; len = 2'd3; cyc = 5'd12; end
                OP_LD_DE_NN: begin {n_d, n_e} = r_imm; len = 2'd3; cyc = 5'd12; end
                OP_LD_HL_NN: begin {n_h, n_l} = r_imm; len = 2'd3; cyc = 5'd12; end
                OP_LD_SP_NN: begin n_sp = r_imm; len = 2'd3; cyc = 5'd12; end
                OP_LD_SP_HL: begin n_sp = hl; cyc = 5'd8; end
                OP_LDHL_SPN: begin
                    {n_h, n_l} = hlsum;
                    n_f = {2'b00, hsum[4], lsum[8], 4'd0};
                    len = 2'd2;
                    cyc = 5'd12;
                end
                OP_ST_NN_SP: begin len = 2'd3; cyc = 5'd20; end
                OP_PUSH_BC, OP_PUSH_DE, OP_PUSH_HL, OP_PUSH_AF: begin
                    n_sp = r_sp - 16'd2;
                    cyc = 5'd16;
                end
                OP_POP_BC: begin n_b = i_rdata; n_c = r_lo; n_sp = r_sp + 16'd2; cyc = 5'd12; end
                OP_POP_DE: begin n_d = i_rdata; n_e = r_lo; n_sp = r_sp + 16'd2; cyc = 5'd12; end
                OP_POP_HL: begin n_h = i_rdata; n_l = r_lo; n_sp = r_sp + 16'd2; cyc = 5'd12; end
                OP_POP_AF: begin
                    n_a = i_rdata;
                    n_f = {r_lo[7:4], 4'd0};
                    n_sp = r_sp + 16'd2;
                    cyc = 5'd12;
                end
                default: begin
                    bad = 1'b1;
                    len = 2'd0;
                    cyc = 5'd0;
                end
            endcase
        end
        n_pc = r_pc + {14'd0, len};
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (acc) n_state = S_B;
            S_B: begin
                if (two) begin
                    n_state = S_C;
                end else if (i_go) begin
                    n_state = S_IDLE;
                end
            end
            S_C: if (i_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_a <= '0; r_f <= '0; r_b <= '0; r_c <= '0;
            r_d <= '0; r_e <= '0; r_h <= '0; r_l <= '0;
            r_sp <= '0;
            r_pc <= '0;
        end else begin
            r_state <= n_state;
            if (o_fin) begin
                r_a <= n_a; r_f <= n_f; r_b <= n_b; r_c <= n_c;
                r_d <= n_d; r_e <= n_e; r_h <= n_h; r_l <= n_l;
                r_sp <= n_sp;
                r_pc <= n_pc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op  <= i_in.operation;
            r_imm <= i_in.immediate;
        end
        if (r_state == S_B) begin
            r_lo <= i_rdata;
        end
    end

    always_comb begin
        o_res.reg_a           = n_a;
        o_res.reg_flags       = n_f & 8'hF0;
        o_res.reg_b           = n_b;
        o_res.reg_c           = n_c;
        o_res.reg_d           = n_d;
        o_res.reg_e           = n_e;
        o_res.reg_h           = n_h;
        o_res.reg_l           = n_l;
        o_res.stack_pointer   = n_sp;
        o_res.program_counter = n_pc;
        o_res.cycle_count     = cyc;
        o_res.unsupported     = bad;
    end

    `LAE_ASSERT_NOW(a_no_acc_clr, i_mem_busy, !acc, "transaction accepted during memory clear")
    `LAE_ASSERT_NOW(a_fin_slot, o_fin, i_go, "result finished with output slot full")
    `LAE_ASSERT_NEXT(a_two_step, (r_state == S_B) && two, r_state == S_C, "two-step op skipped")
    `LAE_ASSERT_NOW(a_one_port, o_req.we, !o_req.re, "read and write in one cycle")

endmodule

/* rtl/cpu_load_alu_execute_unit.sv */
// Executes one LR35902 load or 8-bit add/subtract instruction per input transaction and
// returns all registers, SP, PC and the cycle count in one result transaction. An instruction
// is accepted in S_IDLE and finishes in S_B; PUSH, POP and LD (nn),SP go on to finish in S_C,
// because the single-port data memory moves one byte per cycle. After reset the data memory is
// cleared one byte per cycle, so no input is taken until all 65536 bytes have been cleared. A
// finished result waits in an output register while the next instruction is already accepted.
module cpu_load_alu_execute_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  lae_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output lae_pkg::t_out  o_out_data
);
    import lae_pkg::*;

    t_mem_req   req;
    logic [7:0] rdata;
    logic       mem_busy, go, fin;
    t_out       res;
    t_out       r_out;
    logic       r_ovalid;

    assign go = !r_ovalid || !i_out_stall;

    lae_dmem u_dmem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rdata (rdata),
        .o_busy  (mem_busy)
    );

    lae_exec u_exec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_in       (i_in_data),
        .o_stall    (o_in_stall),
        .i_go       (go),
        .o_fin      (fin),
        .o_res      (res),
        .o_req      (req),
        .i_rdata    (rdata),
        .i_mem_busy (mem_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (fin) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule
